// File: design/tcst_pkg.sv
`default_nettype none

package tcst_pkg;

    // Field widths of one segment header word and one result word
    localparam int FLAGS_W = 8;
    localparam int SEQ_W   = 32;
    localparam int LEN_W   = 16;
    localparam int STATE_W = 4;

    localparam int IN_DATA_W  = FLAGS_W + SEQ_W + SEQ_W + LEN_W;
    localparam int OUT_DATA_W = STATE_W + STATE_W + SEQ_W + SEQ_W + SEQ_W;

    // Bit positions in the TCP flag byte
    localparam int FLAG_FIN = 0;
    localparam int FLAG_SYN = 1;
    localparam int FLAG_RST = 2;
    localparam int FLAG_ACK = 4;

    // Direction of a segment
    localparam logic DIR_LOCAL = 1'b0;
    localparam logic DIR_PEER  = 1'b1;

    // Connection state codes as reported on the result word
    typedef enum logic [STATE_W-1:0] {
        ST_CLOSED      = 4'd0,
        ST_SYN_SENT    = 4'd2,
        ST_SYN_RCVD    = 4'd3,
        ST_ESTABLISHED = 4'd4,
        ST_CLOSE_WAIT  = 4'd5,
        ST_FIN_WAIT_1  = 4'd6,
        ST_CLOSING     = 4'd7,
        ST_LAST_ACK    = 4'd8,
        ST_FIN_WAIT_2  = 4'd9,
        ST_TIME_WAIT   = 4'd10
    } tcp_state_t;

    // Serial-number compares on the signed 32-bit difference
    function automatic logic seq_geq(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return ~d[SEQ_W-1];
    endfunction

    function automatic logic seq_gt(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return (d != '0) && ~d[SEQ_W-1];
    endfunction

endpackage

`default_nettype wire

// File: design/tcp_connection_state_tracker.sv
// A result word becomes valid once its accepted segment word has passed through
// the input register and then the result register.
// Throughput: one segment word per cycle while the result output is not blocked; the
// state update is a single pass of compare/add/select logic between the input register and the state registers.
// Reset (rst_n low, asynchronous): both states CLOSED, all sequence registers zero,
// both pipeline stages empty.
`default_nettype none

module tcp_connection_state_tracker
    import tcst_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // segment words
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // tcp_flags, seq_number, ack_number, payload_len
    input  wire logic                  s_axis_tuser,  // op
    // result words
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata   // out_state, out_pending_state,
                                                      // out_send_unacked, out_send_next,
                                                      // out_send_max
);

    // Input stage
    logic                 in_valid_reg;
    logic                 in_op_reg;
    logic [FLAGS_W-1:0]   in_flags_reg;
    logic [SEQ_W-1:0]     in_seq_reg;
    logic [SEQ_W-1:0]     in_ack_reg;
    logic [LEN_W-1:0]     in_len_reg;

    // Tracker state
    tcp_state_t           conn_state_reg, conn_state_next;
    tcp_state_t           pending_state_reg, pending_state_next;
    logic [SEQ_W-1:0]     ack_gate_seq_reg, ack_gate_seq_next;
    logic [SEQ_W-1:0]     send_unacked_reg, send_unacked_next;
    logic [SEQ_W-1:0]     send_next_reg, send_next_next;
    logic [SEQ_W-1:0]     send_max_reg, send_max_next;

    // Result stage
    logic                 out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic                 in_accept;
    logic                 stage_adv;

    // Handshake: input stage moves on when the result register is free or being drained
    assign stage_adv     = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || stage_adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (stage_adv)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_op_reg    <= s_axis_tuser;
            in_flags_reg <= s_axis_tdata[FLAGS_W-1:0];
            in_seq_reg   <= s_axis_tdata[FLAGS_W +: SEQ_W];
            in_ack_reg   <= s_axis_tdata[FLAGS_W+SEQ_W +: SEQ_W];
            in_len_reg   <= s_axis_tdata[FLAGS_W+2*SEQ_W +: LEN_W];
        end
    end

    // State update for one segment
    always_comb
    begin
        logic             f_fin;
        logic             f_syn;
        logic             f_rst;
        logic             f_ack;
        logic             acked;
        logic             done;
        logic [SEQ_W-1:0] len_ext;
        logic [SEQ_W-1:0] seq_len;
        logic [SEQ_W-1:0] seq_len_fin;
        logic [SEQ_W-1:0] seq_one;
        tcp_state_t       pre_state;
        logic [SEQ_W-1:0] pre_mark;
        logic             pre_hit;

        f_fin       = in_flags_reg[FLAG_FIN];
        f_syn       = in_flags_reg[FLAG_SYN];
        f_rst       = in_flags_reg[FLAG_RST];
        f_ack       = in_flags_reg[FLAG_ACK];
        len_ext     = {{(SEQ_W-LEN_W){1'b0}}, in_len_reg};
        seq_len     = in_seq_reg + len_ext;
        seq_len_fin = seq_len + 32'd1;
        seq_one     = in_seq_reg + 32'd1;
        acked       = f_ack && seq_geq(in_ack_reg, send_next_reg);
        done        = 1'b0;
        pre_state   = ST_CLOSED;
        pre_mark    = '0;
        pre_hit     = 1'b0;

        conn_state_next    = conn_state_reg;
        pending_state_next = pending_state_reg;
        ack_gate_seq_next  = ack_gate_seq_reg;
        send_unacked_next  = send_unacked_reg;
        send_next_next     = send_next_reg;
        send_max_next      = send_max_reg;

        if (f_rst)
        begin
            conn_state_next = ST_CLOSED;
        end
        else if (in_op_reg == DIR_LOCAL)
        begin
            // Local ACK at or past the mark commits the pending state
            if ((pending_state_reg != conn_state_reg) && f_ack
                && seq_geq(in_ack_reg, ack_gate_seq_reg))
            begin
                if (seq_gt(send_next_reg, send_max_reg))
                begin
                    send_max_next = send_next_reg;
                end
                conn_state_next = pending_state_reg;
            end

            case (conn_state_next)
                ST_CLOSED:
                begin
                    if (f_syn && !f_ack)
                    begin
                        send_next_next     = seq_one;
                        send_max_next      = seq_one;
                        send_unacked_next  = seq_one;
                        conn_state_next    = ST_SYN_SENT;
                        pending_state_next = ST_SYN_SENT;
                        done               = 1'b1;
                    end
                end
                ST_SYN_RCVD:
                begin
                    if (f_ack && !f_syn && seq_gt(in_seq_reg, send_next_reg))
                    begin
                        if (seq_gt(send_next_reg, send_max_next))
                        begin
                            send_max_next = send_next_reg;
                        end
                        conn_state_next = pending_state_reg;
                        done            = 1'b1;
                    end
                end
                ST_ESTABLISHED, ST_CLOSE_WAIT:
                begin
                    if (f_fin)
                    begin
                        send_next_next = seq_len_fin;
                        if (seq_gt(seq_len_fin, send_max_next))
                        begin
                            send_max_next = seq_len_fin;
                        end
                        if (conn_state_next == ST_ESTABLISHED)
                        begin
                            conn_state_next    = ST_FIN_WAIT_1;
                            pending_state_next = ST_FIN_WAIT_1;
                        end
                        else
                        begin
                            conn_state_next    = ST_LAST_ACK;
                            pending_state_next = ST_LAST_ACK;
                        end
                        done = 1'b1;
                    end
                end
                ST_FIN_WAIT_1:
                begin
                    if (f_ack && !f_fin)
                    begin
                        if (seq_gt(send_next_reg, send_max_next))
                        begin
                            send_max_next = send_next_reg;
                        end
                        conn_state_next = pending_state_reg;
                        done            = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            // Plain data segment advances send next
            if (!done && (in_len_reg != '0))
            begin
                send_next_next = seq_len;
                if (seq_gt(seq_len, send_max_next))
                begin
                    send_max_next = seq_len;
                end
            end
        end
        else
        begin
            if (f_ack && seq_gt(in_ack_reg, send_unacked_reg))
            begin
                send_unacked_next = in_ack_reg;
            end

            // Pick the pending target and its ack mark
            case (conn_state_reg)
                ST_SYN_SENT:
                begin
                    if (f_syn && !f_ack)
                    begin
                        pre_hit   = 1'b1;
                        pre_state = ST_SYN_RCVD;
                        pre_mark  = seq_one;
                    end
                    else if (f_syn && acked)
                    begin
                        pre_hit   = 1'b1;
                        pre_state = ST_ESTABLISHED;
                        pre_mark  = in_seq_reg;
                    end
                end
                ST_SYN_RCVD:
                begin
                    if (acked)
                    begin
                        pre_hit   = 1'b1;
                        pre_state = ST_ESTABLISHED;
                        pre_mark  = in_seq_reg;
                    end
                end
                ST_ESTABLISHED:
                begin
                    if (f_fin)
                    begin
                        pre_hit   = 1'b1;
                        pre_state = ST_CLOSE_WAIT;
                        pre_mark  = seq_one;
                    end
                end
                ST_FIN_WAIT_1:
                begin
                    if (f_fin)
                    begin
                        pre_hit   = 1'b1;
                        pre_state = acked ? ST_TIME_WAIT : ST_CLOSING;
                        pre_mark  = seq_len_fin;
                    end
                    else if (acked)
                    begin
                        pre_hit   = 1'b1;
                        pre_state = ST_FIN_WAIT_2;
                        pre_mark  = seq_len;
                    end
                end
                ST_FIN_WAIT_2:
                begin
                    if (f_fin)
                    begin
                        pre_hit   = 1'b1;
                        pre_state = ST_TIME_WAIT;
                        pre_mark  = seq_len_fin;
                    end
                end
                ST_CLOSING, ST_LAST_ACK:
                begin
                    if (acked)
                    begin
                        pre_hit   = 1'b1;
                        pre_state = (conn_state_reg == ST_CLOSING) ? ST_TIME_WAIT : ST_CLOSED;
                        pre_mark  = seq_len;
                    end
                end
                default:
                begin
                end
            endcase

            if (pre_hit && (pending_state_reg != pre_state))
            begin
                pending_state_next = pre_state;
                ack_gate_seq_next  = pre_mark;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conn_state_reg    <= ST_CLOSED;
            pending_state_reg <= ST_CLOSED;
            ack_gate_seq_reg  <= '0;
            send_unacked_reg  <= '0;
            send_next_reg     <= '0;
            send_max_reg      <= '0;
        end
        else if (stage_adv)
        begin
            conn_state_reg    <= conn_state_next;
            pending_state_reg <= pending_state_next;
            ack_gate_seq_reg  <= ack_gate_seq_next;
            send_unacked_reg  <= send_unacked_next;
            send_next_reg     <= send_next_next;
            send_max_reg      <= send_max_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_adv)
        begin
            out_data_reg <= {send_max_next, send_next_next, send_unacked_next,
                             pending_state_next, conn_state_next};
        end
    end

    // Input side stalls only when both stages hold words and the output is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a blocked result word");

    // Tracker state holds while no segment is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_adv |=> ($stable(conn_state_reg) && $stable(pending_state_reg)
                        && $stable(send_next_reg) && $stable(send_max_reg)))
        else $error("tracker state changed with no segment processed");

    // RST closes the committed state and leaves the pending state alone
    a_rst_close: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_adv && in_flags_reg[FLAG_RST]) |=>
            ((conn_state_reg == ST_CLOSED) && $stable(pending_state_reg)))
        else $error("RST segment did not close the connection cleanly");

endmodule

`default_nettype wire
